[src/fomo_pkg.sv]
package fomo_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam int PH_W      = 58;
  localparam int PHASE_W   = 57;
  localparam int ANG_W     = 36;
  localparam int XY_W      = 34;
  localparam int TRIG_W    = 19;
  localparam int RED_STEPS = 22;
  localparam int RV_W      = 50;
  localparam int WG_W      = 41;

  localparam int SC_FIXED_LAT = RED_STEPS + 4;
  localparam int POST_LAT     = 5;

  localparam longint TWO_PI_Q32     = 64'sd26986075409;
  localparam longint PI_Q32         = 64'sd13493037704;
  localparam longint HALF_PI_Q32    = 64'sd6746518852;
  localparam longint QUARTER_PI_Q32 = 64'sd3373259426;
  localparam longint CORDIC_GAIN    = 64'sd652032874;

  localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] GAMMA_RESET = 32'sd65536;
  localparam logic [16:0]        REST_RESET  = 17'd52429;

  typedef enum logic [1:0] {
    CFG_FREQ,
    CFG_OFFSET,
    CFG_REST
  } cfg_idx_e;

  typedef enum logic [2:0] {
    G_IDLE,
    G_MUL,
    G_DIFF,
    G_DIV,
    G_SAT,
    G_WG
  } g_state_e;

  typedef struct packed {
    logic signed [31:0] hit_time;
    logic signed [31:0] impact_velocity;
    logic signed [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [23:0]             w;
    logic signed [31:0]      g;
    logic signed [WG_W-1:0]  wg;
    logic                    sat;
  } gamma_t;

  function automatic longint udiv_pos(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'sd1 <<< b);
      end
    end
    return quo;
  endfunction

  function automatic longint atan_pow2(int i);
    longint sum;
    longint term;
    int     e;
    bit     stop;
    sum  = 0;
    stop = 1'b0;
    if (i == 0) begin
      return QUARTER_PI_Q32;
    end
    for (int k = 0; k < 64; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e < 0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        term = udiv_pos(64'sd1 <<< e, longint'(2 * k + 1));
        sum  = ((k & 1) == 1) ? sum - term : sum + term;
      end
    end
    return (sum + (64'sd1 <<< 29)) >>> 30;
  endfunction

endpackage

[src/forced_oscillator_motion_eval_core.sv]
// A start beat passes the phase registers, sin/cos pipelines and combine pipeline in order.
// One beat per cycle unless busy; the sin/cos and multiplier pipelines never stall.
// A forcing_frequency write holds busy while gamma is divided bit-serially.
// Reset: asynchronous, active low; clears valid bits and restores register reset values.
// The receiver cannot stall; each result is shown for exactly one cycle.
module forced_oscillator_motion_eval_core #(
  parameter int CORDIC_STAGES = fomo_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  fomo_pkg::in_item_t   in_i,
  output logic                 result_valid_o,
  output fomo_pkg::out_item_t  result_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);

  localparam int SC_LAT = CORDIC_STAGES + fomo_pkg::SC_FIXED_LAT;
  localparam int PHW    = fomo_pkg::PHASE_W;
  localparam int TW     = fomo_pkg::TRIG_W;

  fomo_pkg::gamma_t gamma;

  logic signed [31:0]                offset_q;
  logic [16:0]                       rest_q;
  logic                              accept;
  logic                              s0_vld_q;
  logic signed [PHW-1:0]             ph0_q, pht_q, phl_q;
  logic signed [fomo_pkg::RV_W-1:0]  rv_q;
  logic signed [fomo_pkg::RV_W-1:0]  rvd_q [SC_LAT];
  logic [SC_LAT-1:0]                 vd_q;
  logic signed [32:0]                lam;
  logic signed [TW-1:0]              c0, s0, cl, sl, cw, sw;

  assign accept = start && !busy;
  assign lam    = 33'(in_i.query_time) - 33'(in_i.hit_time);

  fomo_gamma u_gamma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .gamma_o     (gamma),
    .busy_o      (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      rest_q   <= fomo_pkg::REST_RESET;
      s0_vld_q <= 1'b0;
      vd_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == 2'(fomo_pkg::CFG_OFFSET)) begin
        offset_q <= $signed(cfg_wdata_i);
      end
      if (cfg_we_i && cfg_idx_i == 2'(fomo_pkg::CFG_REST)) begin
        rest_q <= cfg_wdata_i[16:0];
      end
      s0_vld_q <= accept;
      vd_q     <= {vd_q[SC_LAT-2:0], s0_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    ph0_q <= $signed({1'b0, gamma.w}) * in_i.hit_time;
    pht_q <= $signed({1'b0, gamma.w}) * in_i.query_time;
    phl_q <= PHW'($signed({lam, 16'h0000}));
    rv_q  <= $signed({1'b0, rest_q}) * in_i.impact_velocity;
    rvd_q[0] <= rv_q;
  end

  for (genvar k = 1; k < SC_LAT; k++) begin : g_rv_dly
    always_ff @(posedge clk_i) begin
      rvd_q[k] <= rvd_q[k-1];
    end
  end

  fomo_sincos #(.STAGES(CORDIC_STAGES)) u_sc_impact (
    .clk_i   (clk_i),
    .phase_i (ph0_q),
    .cos_o   (c0),
    .sin_o   (s0)
  );

  fomo_sincos #(.STAGES(CORDIC_STAGES)) u_sc_flight (
    .clk_i   (clk_i),
    .phase_i (phl_q),
    .cos_o   (cl),
    .sin_o   (sl)
  );

  fomo_sincos #(.STAGES(CORDIC_STAGES)) u_sc_force (
    .clk_i   (clk_i),
    .phase_i (pht_q),
    .cos_o   (cw),
    .sin_o   (sw)
  );

  fomo_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vd_q[SC_LAT-1]),
    .c0_i     (c0),
    .s0_i     (s0),
    .cl_i     (cl),
    .sl_i     (sl),
    .cw_i     (cw),
    .sw_i     (sw),
    .rv_i     (rvd_q[SC_LAT-1]),
    .offset_i (offset_q),
    .gamma_i  (gamma),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

[src/fomo_gamma.sv]
module fomo_gamma (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  output fomo_pkg::gamma_t     gamma_o,
  output logic                 busy_o
);

  fomo_pkg::g_state_e state_q, state_d;

  logic [23:0]                      w_q;
  logic [47:0]                      wsq_q;
  logic [48:0]                      dabs_q;
  logic                             dneg_q;
  logic                             dzero_q;
  logic [48:0]                      rem_q;
  logic [48:0]                      num_q;
  logic [48:0]                      quo_q;
  logic [5:0]                       cnt_q;
  logic signed [31:0]               g_q;
  logic signed [fomo_pkg::WG_W-1:0] wg_q;
  logic                             sat_q;

  logic                             wr_freq;
  logic signed [49:0]               diff;
  logic [49:0]                      trial;
  logic                             ge;
  logic signed [56:0]               wg_prod;

  assign wr_freq = cfg_we_i && (cfg_idx_i == 2'(fomo_pkg::CFG_FREQ));
  assign diff    = 50'sh1_0000_0000 - $signed({2'b00, wsq_q});
  assign trial   = {rem_q, num_q[48]};
  assign ge      = trial >= {1'b0, dabs_q};
  assign wg_prod = $signed({1'b0, w_q}) * g_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fomo_pkg::G_IDLE: if (wr_freq) state_d = fomo_pkg::G_MUL;
      fomo_pkg::G_MUL:  state_d = fomo_pkg::G_DIFF;
      fomo_pkg::G_DIFF: state_d = fomo_pkg::G_DIV;
      fomo_pkg::G_DIV:  if (cnt_q == 6'd48) state_d = fomo_pkg::G_SAT;
      fomo_pkg::G_SAT:  state_d = fomo_pkg::G_WG;
      fomo_pkg::G_WG:   state_d = fomo_pkg::G_IDLE;
      default:          state_d = fomo_pkg::G_IDLE;
    endcase
  end

  always_comb begin
    busy_o    = (state_q != fomo_pkg::G_IDLE);
    gamma_o.w   = w_q;
    gamma_o.g   = g_q;
    gamma_o.wg  = wg_q;
    gamma_o.sat = sat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fomo_pkg::G_IDLE;
      w_q     <= '0;
      g_q     <= fomo_pkg::GAMMA_RESET;
      wg_q    <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fomo_pkg::G_IDLE && wr_freq) begin
        w_q <= cfg_wdata_i[23:0];
      end
      if (state_q == fomo_pkg::G_SAT) begin
        if (dzero_q) begin
          g_q   <= fomo_pkg::S32_MAX;
          sat_q <= 1'b1;
        end else if (!dneg_q) begin
          if (quo_q > 49'h0_7FFF_FFFF) begin
            g_q   <= fomo_pkg::S32_MAX;
            sat_q <= 1'b1;
          end else begin
            g_q   <= $signed(quo_q[31:0]);
            sat_q <= 1'b0;
          end
        end else begin
          if (quo_q > 49'h0_8000_0000) begin
            g_q   <= fomo_pkg::S32_MIN;
            sat_q <= 1'b1;
          end else begin
            g_q   <= $signed(~quo_q[31:0] + 32'd1);
            sat_q <= 1'b0;
          end
        end
      end
      if (state_q == fomo_pkg::G_WG) begin
        wg_q <= fomo_pkg::WG_W'((wg_prod + 57'sd32768) >>> 16);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      fomo_pkg::G_MUL: begin
        wsq_q <= w_q * w_q;
      end
      fomo_pkg::G_DIFF: begin
        dneg_q  <= diff[49];
        dzero_q <= (diff == 50'sd0);
        dabs_q  <= diff[49] ? 49'(-diff) : diff[48:0];
        rem_q   <= '0;
        num_q   <= 49'h1_0000_0000_0000;
        quo_q   <= '0;
        cnt_q   <= '0;
      end
      fomo_pkg::G_DIV: begin
        rem_q <= ge ? 49'(trial - {1'b0, dabs_q}) : trial[48:0];
        num_q <= {num_q[47:0], 1'b0};
        quo_q <= {quo_q[47:0], ge};
        cnt_q <= cnt_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

[src/fomo_sincos.sv]
module fomo_sincos #(
  parameter int STAGES = fomo_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk_i,
  input  logic signed [fomo_pkg::PHASE_W-1:0]  phase_i,
  output logic signed [fomo_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [fomo_pkg::TRIG_W-1:0]   sin_o
);

  localparam int PW = fomo_pkg::PH_W;
  localparam int AW = fomo_pkg::ANG_W;
  localparam int XW = fomo_pkg::XY_W;
  localparam int RS = fomo_pkg::RED_STEPS;

  localparam logic [PW-1:0] OFFSET = PW'(fomo_pkg::TWO_PI_Q32) << (RS - 1);
  localparam logic signed [AW-1:0] TWO_PI  = AW'(fomo_pkg::TWO_PI_Q32);
  localparam logic signed [AW-1:0] PI      = AW'(fomo_pkg::PI_Q32);
  localparam logic signed [AW-1:0] HALF_PI = AW'(fomo_pkg::HALF_PI_Q32);

  logic [PW-1:0]        red_q [RS+1];
  logic signed [AW-1:0] wrap_q;
  logic signed [AW-1:0] wrap_d;
  logic signed [AW-1:0] fold_d;
  logic                 neg_d;
  logic signed [XW-1:0] x_q [STAGES+1];
  logic signed [XW-1:0] y_q [STAGES+1];
  logic signed [AW-1:0] z_q [STAGES+1];
  logic                 neg_q [STAGES+1];
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;

  always_ff @(posedge clk_i) begin
    red_q[0] <= PW'($signed(PW'(phase_i)) + $signed(OFFSET));
  end

  for (genvar j = 0; j < RS; j++) begin : g_red
    localparam logic [PW-1:0] MULT = PW'(fomo_pkg::TWO_PI_Q32) << (RS - 1 - j);
    always_ff @(posedge clk_i) begin
      red_q[j+1] <= (red_q[j] >= MULT) ? red_q[j] - MULT : red_q[j];
    end
  end

  always_comb begin
    wrap_d = $signed(red_q[RS][AW-1:0]);
    if (wrap_d >= PI) begin
      wrap_d = wrap_d - TWO_PI;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q <= wrap_d;
  end

  always_comb begin
    fold_d = wrap_q;
    neg_d  = 1'b0;
    if (wrap_q > HALF_PI) begin
      fold_d = wrap_q - PI;
      neg_d  = 1'b1;
    end else if (wrap_q < -HALF_PI) begin
      fold_d = wrap_q + PI;
      neg_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= XW'(fomo_pkg::CORDIC_GAIN);
    y_q[0]   <= '0;
    z_q[0]   <= fold_d;
    neg_q[0] <= neg_d;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ATAN = AW'(fomo_pkg::atan_pow2(i));
    always_ff @(posedge clk_i) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN;
      end
      neg_q[i+1] <= neg_q[i];
    end
  end

  assign xr = (x_q[STAGES] + XW'(8192)) >>> 14;
  assign yr = (y_q[STAGES] + XW'(8192)) >>> 14;

  always_ff @(posedge clk_i) begin
    cos_o <= fomo_pkg::TRIG_W'(neg_q[STAGES] ? -xr : xr);
    sin_o <= fomo_pkg::TRIG_W'(neg_q[STAGES] ? -yr : yr);
  end

endmodule

[src/fomo_combine.sv]
module fomo_combine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [fomo_pkg::TRIG_W-1:0]   c0_i,
  input  logic signed [fomo_pkg::TRIG_W-1:0]   s0_i,
  input  logic signed [fomo_pkg::TRIG_W-1:0]   cl_i,
  input  logic signed [fomo_pkg::TRIG_W-1:0]   sl_i,
  input  logic signed [fomo_pkg::TRIG_W-1:0]   cw_i,
  input  logic signed [fomo_pkg::TRIG_W-1:0]   sw_i,
  input  logic signed [fomo_pkg::RV_W-1:0]     rv_i,
  input  logic signed [31:0]                   offset_i,
  input  fomo_pkg::gamma_t                     gamma_i,
  output logic                                 valid_o,
  output fomo_pkg::out_item_t                  result_o
);

  localparam int TW  = fomo_pkg::TRIG_W;
  localparam int GP  = 32 + TW;
  localparam int WP  = fomo_pkg::WG_W + TW;
  localparam int CCW = 37;
  localparam int SCW = 46;
  localparam int SW  = 68;

  logic [fomo_pkg::POST_LAT-1:0] vld_q;

  logic signed [GP-1:0] gc0_q, gcw1_q, gcw2_q, gcw3_q;
  logic signed [WP-1:0] wgs0_q, wgsw1_q, wgsw2_q, wgsw3_q;
  logic signed [34:0]   rvr_q;
  logic signed [TW-1:0] cl1_q, sl1_q, cl2_q, sl2_q;
  logic signed [CCW-1:0] cc_q;
  logic signed [SCW-1:0] sc_q;
  logic signed [CCW+TW-1:0] a_q, d_q;
  logic signed [SCW+TW-1:0] b_q, c_q;
  logic signed [SW-1:0] xs_q, vs_q;
  logic signed [SW-1:0] xr, vr;
  logic                 xhi, xlo, vhi, vlo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[fomo_pkg::POST_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    gc0_q   <= gamma_i.g * c0_i;
    gcw1_q  <= gamma_i.g * cw_i;
    wgs0_q  <= gamma_i.wg * s0_i;
    wgsw1_q <= gamma_i.wg * sw_i;
    rvr_q   <= 35'((rv_i + fomo_pkg::RV_W'(32768)) >>> 16);
    cl1_q   <= cl_i;
    sl1_q   <= sl_i;

    cc_q    <= CCW'(offset_i) - CCW'((gc0_q + GP'(32768)) >>> 16);
    sc_q    <= SCW'((wgs0_q + WP'(32768)) >>> 16) - SCW'(rvr_q);
    gcw2_q  <= gcw1_q;
    wgsw2_q <= wgsw1_q;
    cl2_q   <= cl1_q;
    sl2_q   <= sl1_q;

    a_q     <= cc_q * cl2_q;
    b_q     <= sc_q * sl2_q;
    c_q     <= sc_q * cl2_q;
    d_q     <= cc_q * sl2_q;
    gcw3_q  <= gcw2_q;
    wgsw3_q <= wgsw2_q;

    xs_q    <= SW'(a_q) + SW'(b_q) + SW'(gcw3_q);
    vs_q    <= SW'(c_q) - SW'(d_q) - SW'(wgsw3_q);
  end

  assign xr  = (xs_q + SW'(32768)) >>> 16;
  assign vr  = (vs_q + SW'(32768)) >>> 16;
  assign xhi = xr > SW'(fomo_pkg::S32_MAX);
  assign xlo = xr < SW'(fomo_pkg::S32_MIN);
  assign vhi = vr > SW'(fomo_pkg::S32_MAX);
  assign vlo = vr < SW'(fomo_pkg::S32_MIN);

  always_ff @(posedge clk_i) begin
    result_o.position <= xhi ? fomo_pkg::S32_MAX : xlo ? fomo_pkg::S32_MIN : xr[31:0];
    result_o.velocity <= vhi ? fomo_pkg::S32_MAX : vlo ? fomo_pkg::S32_MIN : vr[31:0];
    result_o.overflow <= gamma_i.sat | xhi | xlo | vhi | vlo;
  end

  assign valid_o = vld_q[fomo_pkg::POST_LAT-1];

endmodule

[src/fomo_checker.sv]
module fomo_checker #(
  parameter int LAT = fomo_pkg::CORDIC_STAGES_DEF + fomo_pkg::SC_FIXED_LAT
                      + fomo_pkg::POST_LAT + 1
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       cfg_we_i,
  input logic [1:0] cfg_idx_i
);

  a_result_has_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching start beat");

  a_freq_sets_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == 2'(fomo_pkg::CFG_FREQ)) |=> busy)
    else $error("frequency write did not raise busy");

  a_busy_from_freq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(cfg_we_i && cfg_idx_i == 2'(fomo_pkg::CFG_FREQ)))
    else $error("busy rose without a frequency write");

endmodule

bind forced_oscillator_motion_eval_core fomo_checker #(
  .LAT(CORDIC_STAGES + fomo_pkg::SC_FIXED_LAT + fomo_pkg::POST_LAT + 1)
) u_fomo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .cfg_we_i       (cfg_we_i),
  .cfg_idx_i      (cfg_idx_i)
);

[tb/forced_oscillator_motion_eval_core_tb.sv]
module forced_oscillator_motion_eval_core_tb;

  localparam int          STAGES     = fomo_pkg::CORDIC_STAGES_DEF;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          SETTLE     = 60;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam longint      TWO_PI     = 64'sd26986075409;
  localparam longint      PI         = 64'sd13493037704;
  localparam longint      HALF_PI    = 64'sd6746518852;
  localparam longint      ROT_GAIN   = 64'sd652032874;

  typedef struct {
    fomo_pkg::in_item_t query;
    bit                 hold_for_drain;
  } pending_query_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  fomo_pkg::in_item_t  in_i = '0;
  logic                result_valid_o;
  fomo_pkg::out_item_t result_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = fomo_pkg::CFG_FREQ;
  logic [31:0]         cfg_wdata_i = '0;

  pending_query_t      query_q[$];
  fomo_pkg::out_item_t motion_q[$];
  fomo_pkg::in_item_t  cur_query;
  int             gap_left = 0;
  int             idle_cycles = 0;
  int             n_errors = 0;
  int             n_sent = 0;
  int             n_checked = 0;
  int             n_overflow = 0;
  int             n_cfg = 0;

  logic [23:0]    m_freq = 24'd0;
  longint         m_offset = 0;
  longint         m_rest = 52429;
  longint         m_gamma = 65536;
  bit             m_gamma_sat = 1'b0;
  longint         atan_q32[STAGES];

  forced_oscillator_motion_eval_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint arctan_q32(int i);
    longint acc;
    longint term;
    int     e;
    acc = 0;
    if (i == 0) return 64'sd3373259426;
    for (int k = 0; k < 64; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = (64'sd1 <<< e) / longint'(2 * k + 1);
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
    end
    return (acc + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic rotate(input longint phase, output longint cos_v, output longint sin_v);
    longint ang;
    longint xr;
    longint yr;
    longint dx;
    longint dy;
    bit     flip;
    ang  = phase % TWO_PI;
    xr   = ROT_GAIN;
    yr   = 0;
    flip = 1'b0;
    if (ang < 0) ang += TWO_PI;
    if (ang >= PI) ang -= TWO_PI;
    if (ang > HALF_PI) begin
      ang -= PI;
      flip = 1'b1;
    end else if (ang < -HALF_PI) begin
      ang += PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (ang >= 0) begin
        xr -= dx;
        yr += dy;
        ang -= atan_q32[i];
      end else begin
        xr += dx;
        yr -= dy;
        ang += atan_q32[i];
      end
    end
    xr    = rnd_shift(xr, 14);
    yr    = rnd_shift(yr, 14);
    cos_v = flip ? -xr : xr;
    sin_v = flip ? -yr : yr;
  endtask

  task automatic apply_register(input logic [1:0] idx, input logic [31:0] data);
    longint w;
    longint den;
    longint g;
    bit     sat;
    case (idx)
      fomo_pkg::CFG_FREQ: begin
        m_freq = data[23:0];
        w      = longint'(m_freq);
        den    = (64'sd1 <<< 32) - w * w;
        sat    = 1'b0;
        if (den == 0) begin
          g   = 64'sd2147483647;
          sat = 1'b1;
        end else begin
          g = clamp32((64'sd1 <<< 48) / den, sat);
        end
        m_gamma     = g;
        m_gamma_sat = sat;
      end
      fomo_pkg::CFG_OFFSET: m_offset = longint'($signed(data));
      fomo_pkg::CFG_REST:   m_rest = longint'(data[16:0]);
      default: ;
    endcase
  endtask

  task automatic predict_motion(input fomo_pkg::in_item_t q);
    longint              t0;
    longint              v0;
    longint              tq;
    longint              w;
    longint              wg;
    longint              c0, s0, cl, sl, cw, sw;
    longint              cc, sc, xp, vp;
    bit                  ovf;
    fomo_pkg::out_item_t r;
    t0  = longint'(q.hit_time);
    v0  = longint'(q.impact_velocity);
    tq  = longint'(q.query_time);
    w   = longint'(m_freq);
    wg  = rnd_shift(w * m_gamma, 16);
    ovf = m_gamma_sat;
    rotate(w * t0, c0, s0);
    cc = m_offset - rnd_shift(m_gamma * c0, 16);
    sc = -rnd_shift(m_rest * v0, 16) + rnd_shift(wg * s0, 16);
    rotate((tq - t0) * 65536, cl, sl);
    rotate(w * tq, cw, sw);
    xp = clamp32(rnd_shift(cc * cl + sc * sl + m_gamma * cw, 16), ovf);
    vp = clamp32(rnd_shift(sc * cl - cc * sl - wg * sw, 16), ovf);
    r.position = xp[31:0];
    r.velocity = vp[31:0];
    r.overflow = ovf;
    motion_q.insert(motion_q.size(), r);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    n_errors++;
    $display("mismatch %0s: got %h want %h (result %0d)", what, got, want, n_checked);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pending_query_t nxt;
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_motion(cur_query);
        n_sent++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (query_q.size() > 0 &&
                     !(query_q[0].hold_for_drain && motion_q.size() > 0)) begin
          nxt       = query_q.pop_front();
          cur_query = nxt.query;
          in_i      <= nxt.query;
          start     <= 1'b1;
          gap_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    fomo_pkg::out_item_t want;
    if (rst_ni && result_valid_o) begin
      if (motion_q.size() == 0) begin
        report("unexpected beat", result_o.position, '0);
      end else begin
        want = motion_q.pop_front();
        if (result_o.position !== want.position)
          report("position", result_o.position, want.position);
        if (result_o.velocity !== want.velocity)
          report("velocity", result_o.velocity, want.velocity);
        if (result_o.overflow !== want.overflow)
          report("overflow", 32'(result_o.overflow), 32'(want.overflow));
        if (want.overflow) n_overflow++;
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    apply_register(idx, data);
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic queue_query(input logic [31:0] t0, input logic [31:0] v0,
                             input logic [31:0] tq, input bit hold);
    pending_query_t p;
    p.query.hit_time        = t0;
    p.query.impact_velocity = v0;
    p.query.query_time      = tq;
    p.hold_for_drain        = hold;
    query_q.insert(query_q.size(), p);
  endtask

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2:  return $urandom();
      3:        return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default:  return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  task automatic queue_random(input int n);
    logic [31:0] t0;
    for (int i = 0; i < n; i++) begin
      t0 = draw_value();
      queue_query(t0, draw_value(), ($urandom_range(0, 9) == 0) ? t0 : draw_value(),
                  (i % 37 == 19));
    end
  endtask

  task automatic drain_all();
    while (query_q.size() > 0 || start || motion_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < STAGES; i++) atan_q32[i] = arctan_q32(i);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    queue_query(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b0);
    queue_query(32'h0000_0000, 32'hFFFF_0000, 32'h0003_243F, 1'b0);
    queue_query(32'h0000_0000, 32'h0001_0000, 32'h0001_921F, 1'b0);
    queue_query(32'h0006_487F, 32'h0000_8000, 32'hFFFC_DBC1, 1'b0);
    drain_all();

    write_reg(fomo_pkg::CFG_FREQ, 32'h0001_0000);
    write_reg(fomo_pkg::CFG_OFFSET, 32'h7FFF_FFFF);
    write_reg(fomo_pkg::CFG_REST, 32'd0);
    queue_query(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    queue_query(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_random(40);
    drain_all();

    write_reg(fomo_pkg::CFG_FREQ, 32'hFF00_FFFF);
    write_reg(fomo_pkg::CFG_OFFSET, 32'h8000_0000);
    write_reg(fomo_pkg::CFG_REST, 32'h0001_0000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_random(60);
    drain_all();

    write_reg(fomo_pkg::CFG_FREQ, 32'h00FF_FFFF);
    write_reg(fomo_pkg::CFG_REST, 32'h0001_FFFF);
    queue_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    queue_random(60);
    drain_all();

    write_reg(fomo_pkg::CFG_FREQ, 32'h0001_0001);
    write_reg(fomo_pkg::CFG_OFFSET, 32'h0000_0000);
    queue_random(50);
    drain_all();

    write_reg(fomo_pkg::CFG_FREQ, 32'h0000_0000);
    write_reg(fomo_pkg::CFG_OFFSET, 32'hFFFF_0000);
    write_reg(fomo_pkg::CFG_REST, 32'd52429);
    queue_random(60);
    drain_all();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(fomo_pkg::CFG_FREQ,
                ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 196608));
      write_reg(fomo_pkg::CFG_OFFSET, ($urandom_range(0, 1) == 0) ? $urandom() : draw_value());
      write_reg(fomo_pkg::CFG_REST, $urandom_range(0, 131071));
      queue_random(55);
      drain_all();
    end

    $display("%0d queries sent, %0d results checked, %0d flagged overflow, %0d register writes",
             n_sent, n_checked, n_overflow, n_cfg);
    $display("covered resonance, near resonance, zero and maximum frequency, offset extremes");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[forced_oscillator_motion_eval_core.f]
src/fomo_pkg.sv
src/fomo_gamma.sv
src/fomo_sincos.sv
src/fomo_combine.sv
src/forced_oscillator_motion_eval_core.sv
src/fomo_checker.sv
tb/forced_oscillator_motion_eval_core_tb.sv
